// File: sv/pcswl_pkg.sv
// Shared types and constants of the per-client sliding window limiter.
// No dependencies; the front end, back end, top level and testbench import this package.
package pcswl_pkg;

	localparam int KEY_W     = 32;
	localparam int TIME_W    = 32;
	localparam int MAXR_W    = 5;
	localparam int WIN_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;
	localparam int IN_DAT_W  = 64;
	localparam int OUT_DAT_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUESTS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SECONDS = 1'd1;

	localparam int Q_DEPTH = 2;
	localparam int QAW     = 1;
	localparam int QCW     = 2;

	typedef struct packed {
		logic [TIME_W-1:0] now_seconds;
		logic [KEY_W-1:0]  client_key;
	} req_t;

	typedef struct packed {
		logic [MAXR_W-1:0] max_requests;
		logic [WIN_W-1:0]  window_seconds;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic clients_full;
	} stat_t;

endpackage

// File: sv/pcswl_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pcswl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: sv/pcswl_front.sv
// Front end: accepts requests from the input stream into a short queue.
// Depends on pcswl_pkg.
module pcswl_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// client_key [31:0], now_seconds [63:32]
	input  logic [pcswl_pkg::IN_DAT_W-1:0] s_axis_tdata,
	output pcswl_pkg::req_t               q_req,
	output logic                          q_valid,
	input  logic                          q_pop
);
	import pcswl_pkg::*;

	req_t           ent_q [Q_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	logic           push;
	logic           pop;

	assign s_axis_tready = (cnt_q != QCW'(Q_DEPTH));
	assign q_valid       = (cnt_q != '0);
	assign q_req         = ent_q[rd_ptr_q];
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q].client_key  <= s_axis_tdata[KEY_W-1:0];
			ent_q[wr_ptr_q].now_seconds <= s_axis_tdata[KEY_W+TIME_W-1:KEY_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: sv/pcswl_back.sv
// Back end: client lookup, log pruning and the admit decision, one request at a time.
// Depends on pcswl_pkg and pcswl_ram.
module pcswl_back #(
	parameter int CLIENTS   = 16,
	parameter int LOG_DEPTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pcswl_pkg::cfg_t                 cfg,
	input  pcswl_pkg::req_t                 req,
	input  logic                            req_valid,
	output logic                            req_pop,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// limited [0], table_full [1], zero [7:2]
	output logic [pcswl_pkg::OUT_DAT_W-1:0] m_axis_tdata,
	output pcswl_pkg::stat_t                stat
);
	import pcswl_pkg::*;

	localparam int CW   = CLIENTS > 1 ? $clog2(CLIENTS) : 1;
	localparam int FW   = $clog2(CLIENTS + 1);
	localparam int CNTW = $clog2(LOG_DEPTH + 1);
	localparam int SD   = CLIENTS * LOG_DEPTH;
	localparam int SAW  = SD > 1 ? $clog2(SD) : 1;
	localparam int AXW  = SAW + CNTW;
	localparam int CMPW = CNTW > MAXR_W ? CNTW : MAXR_W;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_KEY_RD    = 4'd1;
	localparam logic [3:0] ST_KEY_CMP   = 4'd2;
	localparam logic [3:0] ST_MISS      = 4'd3;
	localparam logic [3:0] ST_CNT_RD    = 4'd4;
	localparam logic [3:0] ST_CNT_WAIT  = 4'd5;
	localparam logic [3:0] ST_STAMP_RD  = 4'd6;
	localparam logic [3:0] ST_STAMP_CHK = 4'd7;
	localparam logic [3:0] ST_DECIDE    = 4'd8;
	localparam logic [3:0] ST_OUT       = 4'd9;

	logic [3:0]        state_q;
	logic [KEY_W-1:0]  key_q;
	logic [TIME_W-1:0] now_q;
	logic [FW-1:0]     fill_q;
	logic [CW-1:0]     idx_q;
	logic [CW-1:0]     slot_q;
	logic [SAW-1:0]    base_q;
	logic [CNTW-1:0]   cnt_q;
	logic [CNTW-1:0]   i_q;
	logic [CNTW-1:0]   kept_q;
	logic              res_limited_q;
	logic              res_full_q;

	logic              key_we;
	logic [KEY_W-1:0]  key_rdata;
	logic              cnt_we;
	logic [CNTW-1:0]   cnt_wdata;
	logic [CNTW-1:0]   cnt_rdata;
	logic              stamp_we;
	logic [SAW-1:0]    stamp_waddr;
	logic [SAW-1:0]    stamp_raddr;
	logic [TIME_W-1:0] stamp_wdata;
	logic [TIME_W-1:0] stamp_rdata;
	logic [TIME_W-1:0] age;
	logic              keep;
	logic              at_limit;
	logic              table_full_now;
	logic              out_load;

	assign req_pop        = (state_q == ST_IDLE) && req_valid;
	assign table_full_now = (fill_q == FW'(CLIENTS));
	assign age            = now_q - stamp_rdata;
	assign keep           = (age <= TIME_W'(cfg.window_seconds));
	assign at_limit       = (kept_q >= CNTW'(LOG_DEPTH)) ||
	                        (CMPW'(kept_q) >= CMPW'(cfg.max_requests));
	assign out_load       = (state_q == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

	assign key_we      = (state_q == ST_MISS) && !table_full_now;
	assign cnt_we      = (state_q == ST_DECIDE);
	assign cnt_wdata   = at_limit ? kept_q : kept_q + 1'b1;
	assign stamp_we    = ((state_q == ST_STAMP_CHK) && keep) ||
	                     ((state_q == ST_DECIDE) && !at_limit);
	assign stamp_waddr = SAW'(AXW'(base_q) + AXW'(kept_q));
	assign stamp_raddr = SAW'(AXW'(base_q) + AXW'(i_q));
	assign stamp_wdata = (state_q == ST_STAMP_CHK) ? stamp_rdata : now_q;

	assign stat.busy         = (state_q != ST_IDLE);
	assign stat.clients_full = table_full_now;

	pcswl_ram #(.WIDTH(KEY_W), .DEPTH(CLIENTS)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (CW'(fill_q)),
		.wdata (key_q),
		.raddr (idx_q),
		.rdata (key_rdata)
	);

	pcswl_ram #(.WIDTH(CNTW), .DEPTH(CLIENTS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (slot_q),
		.wdata (cnt_wdata),
		.raddr (slot_q),
		.rdata (cnt_rdata)
	);

	pcswl_ram #(.WIDTH(TIME_W), .DEPTH(SD)) u_stamp_ram (
		.clk   (clk),
		.we    (stamp_we),
		.waddr (stamp_waddr),
		.wdata (stamp_wdata),
		.raddr (stamp_raddr),
		.rdata (stamp_rdata)
	);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				key_q <= req.client_key;
				now_q <= req.now_seconds;
				idx_q <= '0;
			end
			ST_KEY_CMP: begin
				if (key_rdata == key_q) begin
					slot_q <= idx_q;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			ST_MISS: begin
				res_limited_q <= (cfg.max_requests == '0);
				res_full_q    <= table_full_now;
				slot_q        <= CW'(fill_q);
				base_q        <= SAW'(fill_q * LOG_DEPTH);
				kept_q        <= '0;
			end
			ST_CNT_RD: begin
				base_q <= SAW'(slot_q * LOG_DEPTH);
			end
			ST_CNT_WAIT: begin
				cnt_q  <= cnt_rdata;
				i_q    <= '0;
				kept_q <= '0;
			end
			ST_STAMP_CHK: begin
				i_q <= i_q + 1'b1;
				if (keep) begin
					kept_q <= kept_q + 1'b1;
				end
			end
			ST_DECIDE: begin
				res_limited_q <= at_limit;
				res_full_q    <= 1'b0;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			m_axis_tdata <= {{(OUT_DAT_W-2){1'b0}}, res_full_q, res_limited_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			fill_q        <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (out_load) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= (fill_q == '0) ? ST_MISS : ST_KEY_RD;
					end
				end
				ST_KEY_RD: begin
					state_q <= ST_KEY_CMP;
				end
				ST_KEY_CMP: begin
					if (key_rdata == key_q) begin
						state_q <= ST_CNT_RD;
					end else if (FW'(idx_q) + 1'b1 == fill_q) begin
						state_q <= ST_MISS;
					end else begin
						state_q <= ST_KEY_RD;
					end
				end
				ST_MISS: begin
					if (table_full_now) begin
						state_q <= ST_OUT;
					end else begin
						fill_q  <= fill_q + 1'b1;
						state_q <= ST_DECIDE;
					end
				end
				ST_CNT_RD: begin
					state_q <= ST_CNT_WAIT;
				end
				ST_CNT_WAIT: begin
					state_q <= (cnt_rdata == '0) ? ST_DECIDE : ST_STAMP_RD;
				end
				ST_STAMP_RD: begin
					state_q <= ST_STAMP_CHK;
				end
				ST_STAMP_CHK: begin
					state_q <= (i_q + 1'b1 == cnt_q) ? ST_DECIDE : ST_STAMP_RD;
				end
				ST_DECIDE: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/per_client_sliding_window_limiter.sv
// Per-client sliding window log rate limiter, one result per request.
// The back end takes one request at a time and walks the key RAM and then the timestamp RAM,
// one entry at a time through a single read port, so it takes a new request only after it has
// loaded the result of the previous one into the output register.
// Reset: asynchronous; clears the queue, the sequencer and the client fill count, and sets the
// config to max_requests 16 and window_seconds 1.
module per_client_sliding_window_limiter #(
	parameter int CLIENTS   = 16,
	parameter int LOG_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// client_key [31:0], now_seconds [63:32]
	input  logic [pcswl_pkg::IN_DAT_W-1:0]   s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// limited [0], table_full [1], zero [7:2]
	output logic [pcswl_pkg::OUT_DAT_W-1:0]  m_axis_tdata,
	input  logic                             cfg_we,
	input  logic [pcswl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pcswl_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import pcswl_pkg::*;

	cfg_t  cfg_q;
	req_t  q_req;
	logic  q_valid;
	logic  q_pop;
	stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_requests   <= MAXR_W'(16);
			cfg_q.window_seconds <= WIN_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_REQUESTS:   cfg_q.max_requests   <= cfg_data[MAXR_W-1:0];
				REG_WINDOW_SECONDS: cfg_q.window_seconds <= cfg_data[WIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	pcswl_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.q_req         (q_req),
		.q_valid       (q_valid),
		.q_pop         (q_pop)
	);

	pcswl_back #(.CLIENTS(CLIENTS), .LOG_DEPTH(LOG_DEPTH)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.req           (q_req),
		.req_valid     (q_valid),
		.req_pop       (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.stat          (stat)
	);

	a_pop_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("request popped from an empty queue");

	a_full_queue_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> q_valid)
		else $error("input stalled while the queue holds no request");

	a_pop_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> stat.busy)
		else $error("back end idle after taking a request");

	a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !q_pop)
		else $error("request popped while the back end is busy");

	a_table_full_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clients_full |=> stat.clients_full)
		else $error("client table emptied without a reset");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for per_client_sliding_window_limiter: streams client requests through the
// block and checks every verdict against a behavioral copy of the per-client admission logs.
// Depends on pcswl_pkg and the block's RTL.
module tb;

	import pcswl_pkg::*;

	localparam int CLIENTS     = 16;
	localparam int LOG_DEPTH   = 16;
	localparam int POOL_SIZE   = 14;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic table_full;
		logic limited;
	} verdict_t;

	typedef struct {
		req_t req;
		bit   drain_first;
	} pending_req_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [IN_DAT_W-1:0]  s_axis_tdata  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OUT_DAT_W-1:0] m_axis_tdata;
	logic                 cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [CFG_DAT_W-1:0] cfg_data      = '0;

	pending_req_t request_q[$];
	verdict_t     verdict_q[$];
	int           queued_requests = 0;
	int           taken_requests  = 0;
	int           fail_count      = 0;
	int           cycle_count     = 0;

	logic [4:0]   max_req_m;
	logic [15:0]  window_m;
	logic [31:0]  slot_key [CLIENTS];
	bit           slot_used [CLIENTS];
	logic [31:0]  stamp_mem [CLIENTS][LOG_DEPTH];
	int           stamp_count [CLIENTS];

	logic [31:0]  clock_s;
	logic [31:0]  pool [POOL_SIZE];

	per_client_sliding_window_limiter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		// client_key [31:0], now_seconds [63:32]
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		// limited [0], table_full [1], zero [7:2]
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic verdict_t predict_verdict(input logic [31:0] key, input logic [31:0] now);
		verdict_t    v;
		int          hit;
		int          vacant;
		int          cap;
		int          kept;
		logic [31:0] age;
		hit = -1;
		vacant = -1;
		v = '0;
		cap = (max_req_m > LOG_DEPTH) ? LOG_DEPTH : int'(max_req_m);
		for (int i = 0; i < CLIENTS; i++) begin
			if (slot_used[i]) begin
				if (hit < 0 && slot_key[i] == key)
					hit = i;
			end else if (vacant < 0) begin
				vacant = i;
			end
		end
		if (hit < 0 && vacant < 0) begin
			v.limited = (cap == 0);
			v.table_full = 1'b1;
			return v;
		end
		if (hit < 0) begin
			hit = vacant;
			slot_used[hit] = 1'b1;
			slot_key[hit] = key;
			stamp_count[hit] = 0;
		end
		// drop expired stamps, keep survivors in order
		kept = 0;
		for (int j = 0; j < stamp_count[hit]; j++) begin
			age = now - stamp_mem[hit][j];
			if (age <= {16'd0, window_m}) begin
				stamp_mem[hit][kept] = stamp_mem[hit][j];
				kept++;
			end
		end
		stamp_count[hit] = kept;
		if (kept >= cap) begin
			v.limited = 1'b1;
		end else begin
			stamp_mem[hit][kept] = now;
			stamp_count[hit] = kept + 1;
		end
		return v;
	endfunction

	// request driver
	always @(posedge clk) begin
		int burst_left;
		int gap_left;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			burst_left = 4;
			gap_left = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				verdict_q = {verdict_q,
					predict_verdict(s_axis_tdata[31:0], s_axis_tdata[63:32])};
				taken_requests++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (request_q.size() != 0 &&
						(!request_q[0].drain_first || verdict_q.size() == 0)) begin
					s_axis_tdata <= request_q[0].req;
					s_axis_tvalid <= 1'b1;
					request_q.pop_front();
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) :
							$urandom_range(1, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
					end else begin
						burst_left--;
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// verdict monitor
	always @(posedge clk) begin
		int       rx_ticks;
		int       rx_mode;
		verdict_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_ticks = 0;
			rx_mode = 0;
		end else begin
			rx_ticks++;
			if (rx_ticks % 300 == 0)
				rx_mode = $urandom_range(0, 2);
			case (rx_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 1) == 1);
				default: m_axis_tready <= ($urandom_range(0, 11) == 0);
			endcase
			if (m_axis_tvalid && m_axis_tready) begin
				if (verdict_q.size() == 0) begin
					$display("%0t unexpected verdict: expected none actual %02h", $time,
						m_axis_tdata);
					fail_count++;
				end else begin
					want = verdict_q.pop_front();
					if (m_axis_tdata[0] !== want.limited) begin
						$display("%0t limited mismatch: expected %0b actual %0b", $time,
							want.limited, m_axis_tdata[0]);
						fail_count++;
					end
					if (m_axis_tdata[1] !== want.table_full) begin
						$display("%0t table_full mismatch: expected %0b actual %0b", $time,
							want.table_full, m_axis_tdata[1]);
						fail_count++;
					end
				end
			end
		end
	end

	task automatic queue_request(input logic [31:0] key, input logic [31:0] now,
			input bit drain_first = 1'b0);
		pending_req_t p;
		p.req.client_key = key;
		p.req.now_seconds = now;
		p.drain_first = drain_first;
		request_q = {request_q, p};
		queued_requests++;
	endtask

	task automatic wait_drained();
		while (taken_requests != queued_requests || verdict_q.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MAX_REQUESTS)
			max_req_m = value[4:0];
		else
			window_m = value;
	endtask

	task automatic configure(input logic [4:0] max_val, input logic [15:0] win);
		wait_drained();
		// upper bits of the limit write are junk the block must ignore
		write_register(REG_MAX_REQUESTS, {11'($urandom), max_val});
		write_register(REG_WINDOW_SECONDS, win);
	endtask

	function automatic logic [31:0] next_stamp(input int step_max);
		if ($urandom_range(0, 32) == 0)
			clock_s = $urandom;
		else
			clock_s = clock_s + $urandom_range(0, step_max);
		return clock_s;
	endfunction

	function automatic logic [31:0] pick_key(input int spread);
		if ($urandom_range(0, 19) == 0)
			return $urandom;
		return pool[$urandom_range(0, spread - 1)];
	endfunction

	task automatic run_phase(input logic [4:0] max_val, input logic [15:0] win,
			input int spread, input int count, input int step_max);
		configure(max_val, win);
		for (int n = 0; n < count; n++)
			queue_request(pick_key(spread), next_stamp(step_max), $urandom_range(0, 99) == 0);
	endtask

	initial begin
		max_req_m = 5'd16;
		window_m = 16'd1;
		for (int i = 0; i < CLIENTS; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i] = '0;
			stamp_count[i] = 0;
		end
		pool[0] = 32'h0000_0000;
		pool[1] = 32'hFFFF_FFFF;
		pool[2] = 32'h0A00_0001;
		pool[3] = 32'h0000_0001;
		for (int i = 4; i < POOL_SIZE; i++)
			pool[i] = $urandom;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset limits: expiry by one second, time wrapping at the top of the range
		queue_request(32'h0000_0000, 32'd0);
		queue_request(32'h0000_0000, 32'd0);
		queue_request(32'h0000_0000, 32'd1);
		queue_request(32'h0000_0000, 32'd2);
		queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_request(32'hFFFF_FFFF, 32'd0, 1'b1);

		// zero limit: known client limited, new client still claims an entry
		configure(5'd0, 16'd0);
		queue_request(32'h0000_0000, 32'd3);
		queue_request(32'h0A00_0001, 32'd3);

		// limit of two: fill, expire all, time going backwards
		configure(5'd2, 16'd3);
		queue_request(32'h0000_0001, 32'd100);
		queue_request(32'h0000_0001, 32'd100);
		queue_request(32'h0000_0001, 32'd100);
		queue_request(32'h0000_0001, 32'd104);
		queue_request(32'h0000_0001, 32'd50);
		queue_request(32'h0000_0001, 32'd53);
		queue_request(32'h0000_0001, 32'd53);
		queue_request(32'h0A00_0001, 32'd53);

		clock_s = 32'd1000;
		for (int i = 0; i < POOL_SIZE; i++)
			queue_request(pool[i], next_stamp(2));

		run_phase(5'd3, 16'd5, POOL_SIZE, 100, 3);
		run_phase(5'd31, 16'hFFFF, 3, 100, 2000);
		run_phase(5'd0, 16'd10, POOL_SIZE, 40, 2);
		run_phase(5'd1, 16'd0, 6, 80, 1);
		clock_s = 32'hFFFF_FF80;
		run_phase(5'd17, 16'd20, 5, 100, 4);
		run_phase(5'd8, 16'd1000, 10, 100, 50);
		run_phase(5'd16, 16'd1, 4, 60, 1);

		wait_drained();
		repeat (80) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: filelist.f
sv/pcswl_pkg.sv
sv/pcswl_ram.sv
sv/pcswl_front.sv
sv/pcswl_back.sv
sv/per_client_sliding_window_limiter.sv
tb/sv/tb.sv
